[hdl/dcs_pkg.sv]
package dcs_pkg;

    localparam int DCS_MAX_DIM = 512;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W     = 9;
    localparam int VAL_W     = 32;
    localparam int COL_W     = 9;
    localparam int POS_W     = 19;
    localparam int ROW_W     = 9;
    localparam int SUM_W     = 64;

    localparam logic [CFG_W-1:0] ROW_LENGTH_RESET   = 10'd512;
    localparam logic [CFG_W-1:0] ROWS_IN_PART_RESET = 10'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH   = 1'b0,
        REG_ROWS_IN_PART = 1'b1
    } cfg_reg_t;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ELEMENT = 1'b1;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [IDX_W-1:0]        vector_index;
        logic signed [VAL_W-1:0] vector_value;
        logic signed [VAL_W-1:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] entry_value;
        logic [COL_W-1:0]        column;
        logic [POS_W-1:0]        nonzero_position;
        logic [ROW_W-1:0]        row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    last;
    } out_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] element_value;
        logic [COL_W-1:0]        column;
        logic [POS_W-1:0]        position;
        logic [ROW_W-1:0]        row;
        logic                    row_end;
        logic                    nonzero;
    } elem_info_t;

endpackage

[hdl/dcs_stream_if.sv]
interface dcs_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/dcs_ram.sv]
module dcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[hdl/dcs_front.sv]
module dcs_front #(
    parameter int MAX_DIM = dcs_pkg::DCS_MAX_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dcs_pkg::CFG_W-1:0]           cfg_data,
    dcs_stream_if.sink                          item,
    input  logic                                adv,
    output logic                                b_valid,
    output dcs_pkg::elem_info_t                 b_info,
    output logic signed [dcs_pkg::VAL_W-1:0]    vec_value
);
    import dcs_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0] row_length_reg, row_length_next;
    logic [CFG_W-1:0] rows_in_part_reg, rows_in_part_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [CW-1:0]    row_reg, row_next;
    logic [POS_W-1:0] nz_reg, nz_next;
    logic             b_valid_reg, b_valid_next;
    elem_info_t       b_info_reg, b_info_next;

    logic [LW-1:0] len;
    logic [LW-1:0] rows;
    logic [LW-1:0] col_plus;
    logic [LW-1:0] row_plus;
    logic          accept;
    logic          is_elem;
    logic          nz;
    logic          row_end;
    logic          part_end;
    logic          ram_we;
    logic [VAL_W-1:0] ram_rdata;

    assign accept   = item.valid && adv;
    assign item.ready = adv;
    assign is_elem  = (item.data.action == ACT_ELEMENT);
    assign nz       = (item.data.element_value != '0);

    always_comb
    begin
        if (row_length_reg == '0)
            len = LW'(1);
        else if (32'(row_length_reg) > 32'(MAX_DIM))
            len = LW'(MAX_DIM);
        else
            len = LW'(row_length_reg);

        if (rows_in_part_reg == '0)
            rows = LW'(1);
        else if (32'(rows_in_part_reg) > 32'(MAX_DIM))
            rows = LW'(MAX_DIM);
        else
            rows = LW'(rows_in_part_reg);
    end

    assign col_plus = LW'(col_reg) + LW'(1);
    assign row_plus = LW'(row_reg) + LW'(1);
    assign row_end  = (col_plus >= len);
    assign part_end = (row_plus >= rows);

    always_comb
    begin
        row_length_next   = row_length_reg;
        rows_in_part_next = rows_in_part_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_LENGTH:   row_length_next   = cfg_data;
                REG_ROWS_IN_PART: rows_in_part_next = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        nz_next  = nz_reg;
        if (accept && is_elem)
        begin
            if (nz)
                nz_next = nz_reg + POS_W'(1);
            if (row_end)
            begin
                col_next = '0;
                if (part_end)
                begin
                    row_next = '0;
                    nz_next  = '0;
                end
                else
                begin
                    row_next = CW'(row_plus);
                end
            end
            else
            begin
                col_next = CW'(col_plus);
            end
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_info_next  = b_info_reg;
        if (adv)
        begin
            b_valid_next              = accept && is_elem && (nz || row_end);
            b_info_next.element_value = item.data.element_value;
            b_info_next.column        = COL_W'(col_reg);
            b_info_next.position      = nz_reg;
            b_info_next.row           = ROW_W'(row_reg);
            b_info_next.row_end       = row_end;
            b_info_next.nonzero       = nz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg   <= ROW_LENGTH_RESET;
            rows_in_part_reg <= ROWS_IN_PART_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            nz_reg           <= '0;
            b_valid_reg      <= 1'b0;
        end
        else
        begin
            row_length_reg   <= row_length_next;
            rows_in_part_reg <= rows_in_part_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            nz_reg           <= nz_next;
            b_valid_reg      <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_info_reg <= b_info_next;
    end

    // drop load words aimed past the vector
    assign ram_we = accept && !is_elem && (32'(item.data.vector_index) < 32'(MAX_DIM));

    dcs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIM)
    ) u_vector_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (CW'(item.data.vector_index)),
        .wdata (item.data.vector_value),
        .re    (adv),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign b_valid   = b_valid_reg;
    assign b_info    = b_info_reg;
    assign vec_value = ram_rdata;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_elem && row_end) |=> (col_reg == '0))
        else $error("column count not cleared at row end");

endmodule

[hdl/dcs_back.sv]
module dcs_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             b_valid,
    input  dcs_pkg::elem_info_t              b_info,
    input  logic signed [dcs_pkg::VAL_W-1:0] vec_value,
    output logic                             adv,
    dcs_stream_if.source                     result
);
    import dcs_pkg::*;

    logic                    c_valid_reg, c_valid_next;
    elem_info_t              c_info_reg, c_info_next;
    logic signed [SUM_W-1:0] c_prod_reg, c_prod_next;
    logic                    phase_reg, phase_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic                    res_valid_reg, res_valid_next;
    out_word_t               res_word_reg, res_word_next;

    logic signed [VAL_W-1:0] elem_s;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum_now;
    logic                    two;
    logic                    out_free;
    logic                    c_fire;
    logic                    c_done;
    out_word_t               word;

    assign elem_s = b_info.element_value;
    assign prod   = elem_s * vec_value;

    assign sum_now  = acc_reg + (c_info_reg.nonzero ? c_prod_reg : '0);
    assign two      = c_info_reg.nonzero && c_info_reg.row_end;
    assign out_free = !res_valid_reg || result.ready;
    assign c_fire   = c_valid_reg && out_free;
    assign c_done   = c_fire && (!two || phase_reg);
    assign adv      = !c_valid_reg || c_done;

    always_comb
    begin
        c_valid_next = c_valid_reg;
        c_info_next  = c_info_reg;
        c_prod_next  = c_prod_reg;
        if (adv)
        begin
            c_valid_next = b_valid;
            c_info_next  = b_info;
            c_prod_next  = prod;
        end
    end

    always_comb
    begin
        word.row_index = c_info_reg.row;
        if (c_info_reg.nonzero && !phase_reg)
        begin
            word.kind             = KIND_ENTRY;
            word.entry_value      = c_info_reg.element_value;
            word.column           = c_info_reg.column;
            word.nonzero_position = c_info_reg.position;
            word.row_sum          = '0;
            word.last             = !c_info_reg.row_end;
        end
        else
        begin
            word.kind             = KIND_ROW;
            word.entry_value      = '0;
            word.column           = '0;
            word.nonzero_position = c_info_reg.position + POS_W'(c_info_reg.nonzero);
            word.row_sum          = sum_now;
            word.last             = 1'b1;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        res_word_next  = res_word_reg;
        if (out_free)
            res_valid_next = c_fire;
        if (c_fire)
        begin
            res_word_next = word;
            if (two && !phase_reg)
                phase_next = 1'b1;
        end
        if (c_done)
        begin
            phase_next = 1'b0;
            acc_next   = c_info_reg.row_end ? '0 : sum_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg   <= c_valid_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_info_reg   <= c_info_next;
        c_prod_reg   <= c_prod_next;
        res_word_reg <= res_word_next;
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_word_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (c_valid_reg && c_info_reg.nonzero && c_info_reg.row_end))
        else $error("second word pending without a nonzero at row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !c_done) |=> (c_valid_reg && $stable(c_prod_reg)))
        else $error("stalled product lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (c_done && c_info_reg.row_end) |=> (acc_reg == '0))
        else $error("row sum not cleared after row end");

endmodule

[hdl/dense_to_csr_spmv.sv]
// channel | dir | word        | fields
// item    | in  | in_word_t   | action, vector_index, vector_value, element_value
// result  | out | out_word_t  | kind, entry_value, column, nonzero_position,
//         |     |             | row_index, row_sum, last
// cfg     | in  | write only  | cfg_we, cfg_index, cfg_data
//
// One item per cycle while results are taken; a nonzero at a row end holds the input
// until its second result word is loaded into the single output register.
// Pipeline: vector memory read, 32x32 multiply register, accumulate into output register.
// Reset clears counters, row sum and valids; the vector memory holds garbage until loaded.
// A stalled result holds the whole pipe; the memory read data holds with it.
module dense_to_csr_spmv #(
    parameter int MAX_DIM = dcs_pkg::DCS_MAX_DIM
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dcs_pkg::CFG_W-1:0]     cfg_data,
    dcs_stream_if.sink                    item,
    dcs_stream_if.source                  result
);
    import dcs_pkg::*;

    logic                    adv;
    logic                    b_valid;
    elem_info_t              b_info;
    logic signed [VAL_W-1:0] vec_value;

    dcs_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .adv       (adv),
        .b_valid   (b_valid),
        .b_info    (b_info),
        .vec_value (vec_value)
    );

    dcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .b_valid   (b_valid),
        .b_info    (b_info),
        .vec_value (vec_value),
        .adv       (adv),
        .result    (result)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import dcs_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 700;
    localparam int PRELOAD_MAX   = 16;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_ZERO = 32'sd0;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    dcs_stream_if #(.word_t(in_word_t))  item_if ();
    dcs_stream_if #(.word_t(out_word_t)) result_if ();

    dense_to_csr_spmv u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    logic [CFG_W-1:0]        row_length_q;
    logic [CFG_W-1:0]        rows_in_part_q;
    logic signed [VAL_W-1:0] vec_copy [DCS_MAX_DIM];
    bit                      vec_written [DCS_MAX_DIM];
    logic [COL_W-1:0]        col_pos;
    logic [ROW_W-1:0]        row_pos;
    logic [POS_W-1:0]        nz_total;
    logic signed [SUM_W-1:0] dot_acc;
    out_word_t               csr_due [$];

    int idle_pct     = 8;
    int err_count    = 0;
    int quiet_cycles = 0;
    int elems_sent   = 0;
    int loads_sent   = 0;
    int entry_words  = 0;
    int row_words    = 0;
    int dim_settings = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int dim_limit(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DCS_MAX_DIM)
            return DCS_MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void csr_predict(input in_word_t w);
        int        len;
        int        rows;
        bit        row_end;
        out_word_t o;
        len  = dim_limit(row_length_q);
        rows = dim_limit(rows_in_part_q);
        if (w.action == ACT_LOAD)
        begin
            vec_copy[w.vector_index]    = w.vector_value;
            vec_written[w.vector_index] = 1'b1;
        end
        else
        begin
            row_end = (int'(col_pos) + 1 >= len);
            if (w.element_value != 0)
            begin
                dot_acc = dot_acc + longint'(w.element_value) * longint'(vec_copy[col_pos]);
                o                  = '0;
                o.kind             = KIND_ENTRY;
                o.entry_value      = w.element_value;
                o.column           = col_pos;
                o.nonzero_position = nz_total;
                o.row_index        = row_pos;
                o.last             = !row_end;
                csr_due.push_back(o);
                nz_total = nz_total + 1'b1;
            end
            if (row_end)
            begin
                o                  = '0;
                o.kind             = KIND_ROW;
                o.nonzero_position = nz_total;
                o.row_index        = row_pos;
                o.row_sum          = dot_acc;
                o.last             = 1'b1;
                csr_due.push_back(o);
                dot_acc = '0;
                col_pos = '0;
                if (int'(row_pos) + 1 >= rows)
                begin
                    row_pos  = '0;
                    nz_total = '0;
                end
                else
                begin
                    row_pos = row_pos + 1'b1;
                end
            end
            else
            begin
                col_pos = col_pos + 1'b1;
            end
        end
    endfunction

    function automatic string word_text(input out_word_t w);
        return $sformatf("kind %0d value %0d col %0d pos %0d row %0d sum %0d last %0d",
                         w.kind, w.entry_value, w.column, w.nonzero_position,
                         w.row_index, w.row_sum, w.last);
    endfunction

    always @(negedge clk)
        result_if.ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (csr_due.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result word: %s", $time,
                             word_text(result_if.data));
            end
            else
            begin
                want = csr_due.pop_front();
                if (want.kind == KIND_ROW)
                    row_words++;
                else
                    entry_words++;
                if (result_if.data.kind !== want.kind
                    || result_if.data.entry_value !== want.entry_value
                    || result_if.data.column !== want.column
                    || result_if.data.nonzero_position !== want.nonzero_position
                    || result_if.data.row_index !== want.row_index
                    || result_if.data.row_sum !== want.row_sum
                    || result_if.data.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result word mismatch", $time);
                        $display("  expected %s", word_text(want));
                        $display("  actual   %s", word_text(result_if.data));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic hold_input(input int n);
        @(negedge clk);
        item_if.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_word(input in_word_t w);
        if ($urandom_range(99) < idle_pct)
            hold_input($urandom_range(1, 4));
        @(negedge clk);
        item_if.valid <= 1'b1;
        item_if.data  <= w;
        do @(posedge clk); while (!item_if.ready);
        csr_predict(w);
    endtask

    task automatic load_entry(input int idx, input logic signed [VAL_W-1:0] v);
        in_word_t w;
        w.action        = ACT_LOAD;
        w.vector_index  = IDX_W'(idx);
        w.vector_value  = v;
        w.element_value = $urandom;
        send_word(w);
        loads_sent++;
    endtask

    task automatic send_element(input logic signed [VAL_W-1:0] v);
        in_word_t w;
        if (!vec_written[col_pos]
            && (v != VAL_ZERO || int'(col_pos) + 1 >= dim_limit(row_length_q)))
            load_entry(int'(col_pos), pick_value());
        w.action        = ACT_ELEMENT;
        w.vector_index  = IDX_W'($urandom_range(DCS_MAX_DIM - 1));
        w.vector_value  = $urandom;
        w.element_value = v;
        send_word(w);
        elems_sent++;
    endtask

    // drop valid, then wait out every pending result and the pipe behind it
    task automatic settle();
        hold_input(1);
        while (csr_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] rows);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        row_length_q = len;
        @(negedge clk);
        cfg_index <= REG_ROWS_IN_PART;
        cfg_data  <= rows;
        @(posedge clk);
        rows_in_part_q = rows;
        @(negedge clk);
        cfg_we <= 1'b0;
        dim_settings++;
    endtask

    task automatic test_shrink_mid_row();
        send_element(32'sd5);
        send_element(VAL_ZERO);
        send_element(-32'sd7);
        settle();
        set_dims(10'd2, 10'd64);
        send_element(32'sd9);
        send_element(VAL_ZERO);
        send_element(VAL_ZERO);
    endtask

    task automatic test_value_extremes();
        settle();
        set_dims(10'd4, 10'd2);
        load_entry(0, VAL_MIN);
        load_entry(1, VAL_MIN);
        load_entry(2, VAL_MIN);
        load_entry(3, VAL_MAX);
        send_element(VAL_MAX);
        send_element(-32'sd1);
        send_element(VAL_ZERO);
        send_element(VAL_MIN);
        send_element(VAL_MIN);
        send_element(VAL_MIN);
        send_element(VAL_MIN);
        send_element(VAL_ZERO);
        repeat (4) send_element(VAL_ZERO);
    endtask

    task automatic test_dim_clamp();
        settle();
        set_dims(10'd0, 10'd0);
        send_element(32'sd3);
        send_element(VAL_ZERO);
        settle();
        set_dims(10'd1023, 10'd1023);
        send_element(pick_value());
        send_element(pick_value());
    endtask

    task automatic test_random_parts();
        int               phase;
        int               len;
        int               zero_pct;
        int               count;
        logic [CFG_W-1:0] len_cfg;
        logic [CFG_W-1:0] rows_cfg;
        phase = 0;
        while (elems_sent + loads_sent < ITEM_TARGET)
        begin
            settle();
            idle_pct = (phase % 5 == 2) ? 0 : 8;
            if (phase == 2)
            begin
                len_cfg  = 10'd512;
                rows_cfg = 10'd1;
                zero_pct = 95;
                count    = DCS_MAX_DIM;
            end
            else
            begin
                case ($urandom_range(7))
                    0: len_cfg = 10'd0;
                    1: len_cfg = CFG_W'($urandom_range(513, 1023));
                    default: len_cfg = CFG_W'($urandom_range(1, 12));
                endcase
                case ($urandom_range(5))
                    0: rows_cfg = 10'd0;
                    1: rows_cfg = CFG_W'($urandom_range(500, 1023));
                    default: rows_cfg = CFG_W'($urandom_range(1, 6));
                endcase
                zero_pct = $urandom_range(0, 80);
                count    = $urandom_range(4, 60);
            end
            set_dims(len_cfg, rows_cfg);
            len = dim_limit(len_cfg);
            for (int i = 0; i < len && i < count && i < PRELOAD_MAX; i++)
                load_entry(i, pick_value());
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(15) == 0)
                    load_entry($urandom_range(DCS_MAX_DIM - 1), pick_value());
                send_element(($urandom_range(99) < zero_pct) ? VAL_ZERO : pick_value());
            end
            phase++;
        end
        idle_pct = 8;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_ROW_LENGTH;
        cfg_data        = '0;
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        result_if.ready = 1'b0;
        row_length_q    = ROW_LENGTH_RESET;
        rows_in_part_q  = ROWS_IN_PART_RESET;
        col_pos         = '0;
        row_pos         = '0;
        nz_total        = '0;
        dot_acc         = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_shrink_mid_row();
        test_value_extremes();
        test_dim_clamp();
        test_random_parts();
        settle();

        $display("run covered %0d matrix elements and %0d vector loads over %0d dim settings",
                 elems_sent, loads_sent, dim_settings);
        $display("checked %0d entry words and %0d row words, %0d mismatches",
                 entry_words, row_words, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
